// File: design/ssae_pkg.sv
// Package for the sign-stack add/subtract expression evaluator.
// Character codes, field widths and the stack cell control struct.
// No dependencies.
`default_nettype none

package ssae_pkg;

    // Field widths
    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 32;

    // ASCII codes the evaluator reacts to
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;

    // Shift command broadcast to every stack cell
    typedef struct packed {
        logic push;   // shift toward the bottom, new sign enters the top cell
        logic pop;    // shift toward the top
    } stack_ctrl_t;

endpackage : ssae_pkg

`default_nettype wire

// File: design/ssae_stack_cell.sv
// One cell of the sign stack: holds a single sign bit.
// Takes its neighbor's bit on a push or pop. Depends on ssae_pkg.
`default_nettype none

module ssae_stack_cell (
    input  wire                  clk,
    input  ssae_pkg::stack_ctrl_t ctrl,
    input  wire                  from_above,   // neighbor nearer the top
    input  wire                  from_below,   // neighbor nearer the bottom
    output logic                 sign
);
    import ssae_pkg::*;

    logic sign_reg;
    logic sign_next;

    // Push moves data down, pop moves data up, otherwise hold
    always_comb
    begin
        sign_next = sign_reg;
        if (ctrl.push)
        begin
            sign_next = from_above;
        end
        else if (ctrl.pop)
        begin
            sign_next = from_below;
        end
    end

    // Payload bit, no reset (entries are written by a push before use)
    always_ff @(posedge clk)
    begin
        sign_reg <= sign_next;
    end

    assign sign = sign_reg;

endmodule : ssae_stack_cell

`default_nettype wire

// File: design/sign_stack_add_sub_evaluator.sv
// Top level of the sign-stack add/subtract expression evaluator.
// Instantiates a row of ssae_stack_cell; depends on ssae_pkg.
//
// Evaluates an expression of decimal integers, '+', '-', parentheses and
// spaces, one ASCII character per request on the slave side, the final one
// marked by s_tlast. A new request is accepted every cycle as long as the
// result output is free or being taken; the only thing that stalls input
// is a held result on the master side. The signs of open parentheses live
// in a row of MAX_NESTING cells that shift as a stack, the top in the first
// cell. On the last character the block emits the 32-bit wrapped total in
// m_tdata and an error flag in m_tuser (stack overflow or unmatched ')'),
// then returns to its reset state for the next expression. Unknown
// characters are ignored but end a digit run. Unclosed parentheses are
// not an error.
`default_nettype none

module sign_stack_add_sub_evaluator #(
    parameter int MAX_NESTING = 64
) (
    input  wire         clk,
    input  wire         rst_n,
    // Character requests
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // [7:0] character
    input  wire         s_tlast,    // last character of the expression
    // Results
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,    // [31:0] value
    output logic [0:0]  m_tuser     // [0] error
);
    import ssae_pkg::*;

    localparam int DEPTH_W = $clog2(MAX_NESTING + 1);

    // Evaluator state
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               neg_reg, neg_next;
    logic [VALUE_W-1:0] total_reg, total_next;
    logic [VALUE_W-1:0] num_reg, num_next;
    logic               in_num_reg, in_num_next;
    logic               err_reg, err_next;

    // Result register
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic               out_err_reg, out_err_next;

    logic               accept;
    logic               is_digit;
    logic [VALUE_W-1:0] num_times_ten;
    logic [VALUE_W-1:0] digit_num;
    logic [VALUE_W-1:0] flushed_total;
    logic [VALUE_W-1:0] final_total;
    logic               top_neg;
    stack_ctrl_t        stack_ctrl;
    logic [MAX_NESTING-1:0] cell_sign;

    // Handshake: result register frees up when taken
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Sign stack: cell 0 is the top
    genvar gi;
    generate
        for (gi = 0; gi < MAX_NESTING; gi++)
        begin : g_cell
            logic above, below;
            if (gi == 0)
            begin : g_top
                assign above = neg_reg;
            end
            else
            begin : g_mid
                assign above = cell_sign[gi-1];
            end
            if (gi == MAX_NESTING - 1)
            begin : g_bot
                assign below = 1'b0;
            end
            else
            begin : g_up
                assign below = cell_sign[gi+1];
            end
            ssae_stack_cell u_cell (
                .clk        (clk),
                .ctrl       (stack_ctrl),
                .from_above (above),
                .from_below (below),
                .sign       (cell_sign[gi])
            );
        end
    endgenerate

    assign top_neg = (depth_reg != '0) && cell_sign[0];

    // Digit accumulate: n*10 as two shifts plus an add
    assign is_digit      = s_tdata inside {[CH_ZERO:CH_NINE]};
    assign num_times_ten = {num_reg[VALUE_W-4:0], 3'b000} + {num_reg[VALUE_W-2:0], 1'b0};
    assign digit_num     = num_times_ten + {{(VALUE_W-4){1'b0}}, s_tdata[3:0]};

    // Pending run folded into the total
    assign flushed_total = !in_num_reg ? total_reg :
                           (neg_reg ? total_reg - num_reg : total_reg + num_reg);
    assign final_total   = !is_digit ? flushed_total :
                           (neg_reg ? total_reg - digit_num : total_reg + digit_num);

    // Per-character state update
    always_comb
    begin
        depth_next  = depth_reg;
        neg_next    = neg_reg;
        total_next  = total_reg;
        num_next    = num_reg;
        in_num_next = in_num_reg;
        err_next    = err_reg;
        stack_ctrl  = '0;

        if (accept)
        begin
            if (is_digit)
            begin
                num_next    = digit_num;
                in_num_next = 1'b1;
            end
            else
            begin
                total_next  = flushed_total;
                num_next    = '0;
                in_num_next = 1'b0;
                case (s_tdata)
                    CH_LPAREN:
                    begin
                        if (depth_reg < DEPTH_W'(MAX_NESTING))
                        begin
                            stack_ctrl.push = 1'b1;
                            depth_next      = depth_reg + 1'b1;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    CH_RPAREN:
                    begin
                        if (depth_reg != '0)
                        begin
                            stack_ctrl.pop = 1'b1;
                            depth_next     = depth_reg - 1'b1;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    CH_PLUS:  neg_next = top_neg;
                    CH_MINUS: neg_next = !top_neg;
                    default:  ;
                endcase
            end

            // End of expression: clear for the next one
            if (s_tlast)
            begin
                depth_next  = '0;
                neg_next    = 1'b0;
                total_next  = '0;
                num_next    = '0;
                in_num_next = 1'b0;
                err_next    = 1'b0;
            end
        end
    end

    // Result register load / drain
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;
        if (accept && s_tlast)
        begin
            out_valid_next = 1'b1;
            out_value_next = final_total;
            out_err_next   = err_reg
                             || (!is_digit && (s_tdata == CH_LPAREN)
                                 && (depth_reg >= DEPTH_W'(MAX_NESTING)))
                             || (!is_digit && (s_tdata == CH_RPAREN)
                                 && (depth_reg == '0));
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            neg_reg       <= 1'b0;
            total_reg     <= '0;
            num_reg       <= '0;
            in_num_reg    <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg     <= depth_next;
            neg_reg       <= neg_next;
            total_reg     <= total_next;
            num_reg       <= num_next;
            in_num_reg    <= in_num_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_value_reg;
    assign m_tuser[0] = out_err_reg;

endmodule : sign_stack_add_sub_evaluator

`default_nettype wire
